/* rtl/core/day_count_to_calendar_date_macros.svh */
// Assertion macros for the day count to calendar date block.
// Used by the port checker; depends on nothing else.
`ifndef DAY_COUNT_TO_CALENDAR_DATE_MACROS_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DCC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dcc check failed");

// Next-cycle implication, disabled while reset is asserted
`define DCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dcc check failed");

`endif

/* rtl/core/dcc_pkg.sv */
// Package for the day count to calendar date block: microcode format,
// control store and calendar helper functions. Depends on nothing.
`default_nettype none

package dcc_pkg;

	// Step counter of the sequencer
	typedef logic [1:0] step_t;

	localparam step_t STEP_LOAD  = 2'd0;
	localparam step_t STEP_YEAR  = 2'd1;
	localparam step_t STEP_MONTH = 2'd2;
	localparam step_t STEP_EMIT  = 2'd3;

	// Condition tested by a control word
	typedef enum logic [1:0] {
		COND_IN_VALID,
		COND_YEAR_FITS,
		COND_MONTH_FITS,
		COND_OUT_FREE
	} cond_t;

	// Datapath action, taken only when the condition holds
	typedef enum logic [1:0] {
		ACT_LOAD,
		ACT_SUB_YEAR,
		ACT_SUB_MONTH,
		ACT_EMIT
	} act_t;

	typedef struct packed {
		cond_t cond;
		act_t  act;
		step_t tgt_true;
		step_t tgt_false;
	} ctrl_t;

	localparam logic [12:0] BASE_YEAR = 13'd2000;

	// Control store: one word per step
	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t w;
		unique case (pc)
			STEP_LOAD:  w = '{COND_IN_VALID,   ACT_LOAD,      STEP_YEAR,  STEP_LOAD};
			STEP_YEAR:  w = '{COND_YEAR_FITS,  ACT_SUB_YEAR,  STEP_YEAR,  STEP_MONTH};
			STEP_MONTH: w = '{COND_MONTH_FITS, ACT_SUB_MONTH, STEP_MONTH, STEP_EMIT};
			STEP_EMIT:  w = '{COND_OUT_FREE,   ACT_EMIT,      STEP_LOAD,  STEP_EMIT};
			default:    w = '{COND_IN_VALID,   ACT_LOAD,      STEP_YEAR,  STEP_LOAD};
		endcase
		return w;
	endfunction

	// Days in a month of the given year kind
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] n;
		case (month)
			4'd2:                      n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
			default:                   n = 5'd31;
		endcase
		return n;
	endfunction

	// Residue mod 7 of a value below 35
	function automatic logic [2:0] mod7_small(input logic [4:0] v);
		logic [4:0] r;
		if (v >= 5'd28)      r = v - 5'd28;
		else if (v >= 5'd21) r = v - 5'd21;
		else if (v >= 5'd14) r = v - 5'd14;
		else if (v >= 5'd7)  r = v - 5'd7;
		else                 r = v;
		return r[2:0];
	endfunction

	// Sum of two residues, reduced mod 7
	function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 4'd7) s = s - 4'd7;
		return s[2:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/day_count_to_calendar_date.sv */
// Top level of the day count to calendar date converter.
// Depends on dcc_pkg for the control store and calendar helpers.
`default_nettype none

// Converts a count of days since 2000-01-01 into year, month, day of month and
// weekday (0 is Saturday). Only the low DAY_COUNT_BITS bits of day_count count.
// One word is converted at a time: a small microcoded sequencer removes one
// whole year per cycle, then one whole month per cycle; the year loop sets
// most of the conversion time. The result sits in an output register, so the
// next word is taken while the previous result waits.
module day_count_to_calendar_date #(
	parameter int DAY_COUNT_BITS = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [19:0] day_count, [23:20] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [12:0] year, [16:13] month,
	                                    // [21:17] day_of_month, [24:22] weekday
);
	import dcc_pkg::*;

	localparam int CNT_W = (DAY_COUNT_BITS < 20) ? DAY_COUNT_BITS : 20;

	step_t          pc_q;
	ctrl_t          ctrl;
	logic           cond_ok;

	logic [CNT_W-1:0] d_q;
	logic [12:0]      year_q;
	logic [3:0]       month_q;
	logic [2:0]       wday_q;
	logic [1:0]       m4_q;
	logic [6:0]       m100_q;
	logic [8:0]       m400_q;

	logic             m_tvalid_q;
	logic [24:0]      out_q;

	logic             leap;
	logic [8:0]       ylen;
	logic [4:0]       mlen;
	logic             year_fits;
	logic             month_fits;
	logic             out_free;

	// Decode the current step and its calendar quantities
	always_comb begin
		ctrl       = ucode(pc_q);
		leap       = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
		ylen       = leap ? 9'd366 : 9'd365;
		mlen       = month_len(month_q, leap);
		year_fits  = d_q >= CNT_W'(ylen);
		month_fits = (month_q < 4'd12) && (d_q >= CNT_W'(mlen));
		out_free   = !m_tvalid_q || m_tready;
		case (ctrl.cond)
			COND_IN_VALID:   cond_ok = s_tvalid;
			COND_YEAR_FITS:  cond_ok = year_fits;
			COND_MONTH_FITS: cond_ok = month_fits;
			COND_OUT_FREE:   cond_ok = out_free;
			default:         cond_ok = 1'b0;
		endcase
	end

	assign s_tready = (ctrl.cond == COND_IN_VALID);

	// Advance the step counter and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= STEP_LOAD;
			m_tvalid_q <= 1'b0;
		end else begin
			pc_q <= cond_ok ? ctrl.tgt_true : ctrl.tgt_false;
			if (cond_ok && (ctrl.act == ACT_EMIT)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath: load, remove a year, remove a month, emit
	always_ff @(posedge clk) begin
		if (cond_ok) begin
			case (ctrl.act)
				ACT_LOAD: begin
					d_q     <= s_tdata[CNT_W-1:0];
					year_q  <= BASE_YEAR;
					month_q <= 4'd1;
					wday_q  <= 3'd0;
					m4_q    <= 2'd0;
					m100_q  <= 7'd0;
					m400_q  <= 9'd0;
				end
				ACT_SUB_YEAR: begin
					d_q    <= d_q - CNT_W'(ylen);
					year_q <= year_q + 13'd1;
					// 365 days is one weekday on, 366 is two
					wday_q <= add_mod7(wday_q, leap ? 3'd2 : 3'd1);
					m4_q   <= m4_q + 2'd1;
					m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
					m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
				end
				ACT_SUB_MONTH: begin
					d_q     <= d_q - CNT_W'(mlen);
					month_q <= month_q + 4'd1;
					wday_q  <= add_mod7(wday_q, mod7_small(mlen));
				end
				ACT_EMIT: begin
					out_q <= {add_mod7(wday_q, mod7_small(d_q[4:0])),
					          d_q[4:0] + 5'd1, month_q, year_q};
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_q};

endmodule

`default_nettype wire

/* rtl/core/dcc_checker.sv */
// Port checker for the day count to calendar date block, bound to its top.
// Depends on day_count_to_calendar_date_macros.svh.
`default_nettype none

`include "day_count_to_calendar_date_macros.svh"

module dcc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// Hold a stalled result
	`DCC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Take one word at a time
	`DCC_ASSERT_NEXT(a_one_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// Keep every result field in its calendar range
	`DCC_ASSERT_IMPL(a_range, clk, arst_n, m_tvalid, (m_tdata[12:0] >= 13'd2000) && (m_tdata[16:13] >= 4'd1) && (m_tdata[16:13] <= 4'd12) && (m_tdata[21:17] >= 5'd1) && (m_tdata[24:22] <= 3'd6))

	// Cap February at 29 days and short months at 30
	`DCC_ASSERT_IMPL(a_month_len, clk, arst_n, m_tvalid && ((m_tdata[16:13] == 4'd2) || (m_tdata[16:13] == 4'd4) || (m_tdata[16:13] == 4'd6) || (m_tdata[16:13] == 4'd9) || (m_tdata[16:13] == 4'd11)), (m_tdata[21:17] <= 5'd30) && ((m_tdata[16:13] != 4'd2) || (m_tdata[21:17] <= 5'd29)))

endmodule

bind day_count_to_calendar_date dcc_checker u_dcc_checker (.*);

`default_nettype wire

/* tb/tb_day_count_to_calendar_date.sv */
// Testbench for day_count_to_calendar_date: drives day counts on the input stream and checks
// each result word against a calendar predictor kept in a small class.
// Depends only on the RTL top level; the package is not needed.
`timescale 1ns / 1ps

module tb_day_count_to_calendar_date;

	localparam int          DAY_COUNT_BITS = 20;
	localparam int unsigned MAX_COUNT      = (1 << DAY_COUNT_BITS) - 1;
	localparam int unsigned DAYS_PER_CYCLE = 146097;
	localparam int          WATCHDOG_LIMIT = 20000;
	localparam int          SETTLE_CYCLES  = 3000;

	// Result word layout, lowest field last
	typedef struct packed {
		logic [6:0]  pad;
		logic [2:0]  weekday;
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [12:0] year;
	} cal_date_t;

	typedef struct {
		logic [19:0] count;
		cal_date_t   date;
	} pending_date_t;

	// Predicts dates for accepted counts and checks result words in order
	class calendar_checker;
		pending_date_t expected_dates[$];
		int errors;
		int mismatches;
		int checked;
		int min_year;
		int max_year;

		function new();
			errors = 0;
			mismatches = 0;
			checked = 0;
			min_year = 9999;
			max_year = 0;
		endfunction

		function bit is_leap(input int unsigned yr);
			return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
		endfunction

		function int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
			if (mo == 2) begin
				return is_leap(yr) ? 29 : 28;
			end
			if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
				return 30;
			end
			return 31;
		endfunction

		// Peel whole 400-year cycles, then single years, then months
		function cal_date_t to_calendar(input logic [19:0] count);
			cal_date_t   dt;
			int unsigned d;
			int unsigned yr;
			int unsigned mo;
			int unsigned ylen;
			int unsigned mlen;
			d = count & MAX_COUNT;
			dt.pad = '0;
			dt.weekday = 3'(d % 7);
			yr = 2000 + 400 * (d / DAYS_PER_CYCLE);
			d = d % DAYS_PER_CYCLE;
			while (1) begin
				ylen = is_leap(yr) ? 366 : 365;
				if (d < ylen) break;
				d = d - ylen;
				yr++;
			end
			mo = 1;
			while (mo < 12) begin
				mlen = days_in_month(mo, yr);
				if (d < mlen) break;
				d = d - mlen;
				mo++;
			end
			dt.year = 13'(yr);
			dt.month = 4'(mo);
			dt.day_of_month = 5'(d + 1);
			return dt;
		endfunction

		function void note_count(input logic [19:0] count);
			pending_date_t p;
			p.count = count;
			p.date = to_calendar(count);
			expected_dates.push_back(p);
		endfunction

		function void check_word(input logic [31:0] word);
			pending_date_t p;
			cal_date_t     got;
			got = cal_date_t'(word);
			if (expected_dates.size() == 0) begin
				errors++;
				if (mismatches < 10) begin
					$display("unexpected result word %h with no count pending", word);
				end
				mismatches++;
				return;
			end
			p = expected_dates.pop_front();
			checked++;
			if (int'(p.date.year) < min_year) min_year = p.date.year;
			if (int'(p.date.year) > max_year) max_year = p.date.year;
			if (got.year !== p.date.year || got.month !== p.date.month ||
					got.day_of_month !== p.date.day_of_month ||
					got.weekday !== p.date.weekday || got.pad !== p.date.pad) begin
				errors++;
				if (mismatches < 10) begin
					$display("count %0d: expected %0d-%0d-%0d wd %0d pad %0d, got %0d-%0d-%0d wd %0d pad %0d",
						p.count, p.date.year, p.date.month, p.date.day_of_month,
						p.date.weekday, p.date.pad, got.year, got.month,
						got.day_of_month, got.weekday, got.pad);
				end
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_dates.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // [19:0] day_count, [23:20] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [12:0] year, [16:13] month, [21:17] day_of_month,
	                             // [24:22] weekday

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int idle_cycles = 0;

	calendar_checker dates = new();

	day_count_to_calendar_date #(
		.DAY_COUNT_BITS(DAY_COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Run the clock
	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Stall the result side at random
	initial begin
		forever begin
			@(posedge clk);
			m_tready <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Check every accepted result word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			dates.check_word(m_tdata);
		end
	end

	// Stop the run when no word moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d dates pending",
				WATCHDOG_LIMIT, dates.pending());
			$display("tb_day_count_to_calendar_date: errors");
			$finish;
		end
	end

	// Offer one count, with random idle cycles ahead of it, and hold until taken
	task automatic send_count(input logic [19:0] count);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, count};
		do begin
			@(posedge clk);
		end while (!s_tready);
		dates.note_count(count);
	endtask

	// Hold off the input until every pending date has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (dates.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Mix full-range counts, short counts and counts next to year ends and leap days
	function automatic logic [19:0] random_count();
		int          kind;
		int unsigned yrs;
		int unsigned base;
		int unsigned c;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			return 20'($urandom_range(0, MAX_COUNT));
		end
		if (kind < 65) begin
			return 20'($urandom_range(0, 1500));
		end
		yrs = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2869);
		base = 0;
		for (int unsigned y = 0; y < yrs; y++) begin
			base += dates.is_leap(2000 + y) ? 366 : 365;
		end
		if ($urandom_range(0, 1) == 0) begin
			c = base + $urandom_range(0, 3);
			c = (c >= 2) ? c - 2 : 0;
		end else begin
			c = base + 57 + $urandom_range(0, 3);
		end
		if (c > MAX_COUNT) c = MAX_COUNT;
		return 20'(c);
	endfunction

	logic [19:0] directed_counts[] = '{
		20'd0, 20'd1, 20'd30, 20'd31, 20'd58, 20'd59, 20'd60,
		20'd365, 20'd366, 20'd730, 20'd731,
		20'd36524, 20'd36525, 20'd36583, 20'd36584,
		20'd146096, 20'd146097, 20'd146156,
		20'h7FFFF, 20'hAAAAA, 20'h55555, 20'hFFFFE, 20'hFFFFF
	};

	initial begin
		// Hold reset, then release on an edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Slow receiver: calendar edges, century rules, cycle boundary, count extremes
		tx_idle_pct = 29;
		rx_idle_pct = 71;
		foreach (directed_counts[i]) begin
			send_count(directed_counts[i]);
		end
		repeat (39) send_count(random_count());
		wait_drained();

		// Slow sender
		tx_idle_pct = 71;
		rx_idle_pct = 29;
		repeat (39) send_count(random_count());
		wait_drained();

		// Back to back on both sides
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (39) send_count(random_count());
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (dates.pending() != 0) begin
			dates.errors += dates.pending();
		end
		$display("checked %0d dates, years %0d to %0d, under three pacing mixes",
			dates.checked, dates.min_year, dates.max_year);
		$display("%0d mismatching or stray result words", dates.mismatches);
		if (dates.errors == 0) begin
			$display("tb_day_count_to_calendar_date: clean");
		end else begin
			$display("tb_day_count_to_calendar_date: errors");
		end
		$finish;
	end

endmodule
